[sv/tdrs_pkg.sv]
// shared types, codes and constants for the time-of-day relay scheduler
package tdrs_pkg;

  localparam int unsigned SLOTS      = 24;
  localparam int unsigned SLOT_W     = 5;
  localparam int unsigned HOUR_W     = 5;
  localparam int unsigned MIN_W      = 6;
  localparam int unsigned SEC_W      = 6;
  localparam int unsigned BYTE_W     = 8;

  localparam logic [HOUR_W-1:0] HOUR_MAX = HOUR_W'(23);
  localparam logic [MIN_W-1:0]  MIN_MAX  = MIN_W'(59);
  localparam logic [SEC_W-1:0]  SEC_MAX  = SEC_W'(59);

  localparam logic [BYTE_W-1:0] SLOT_ON  = 8'hff;
  localparam logic [BYTE_W-1:0] SLOT_OFF = 8'h00;

  typedef enum logic [1:0] {
    ACT_TICK       = 2'd0,
    ACT_SET_TIME   = 2'd1,
    ACT_WRITE_SLOT = 2'd2
  } action_e;

  typedef struct packed {
    logic              en;
    logic [SLOT_W-1:0] idx;
    logic [BYTE_W-1:0] bits;
  } sched_wr_t;

  typedef struct packed {
    logic [HOUR_W-1:0] hour_now;
    logic [MIN_W-1:0]  minute_now;
    logic [SEC_W-1:0]  second_now;
    logic              second_boundary;
    logic              sample_due;
    logic              report_due;
    logic              relay_on;
    logic              led_on;
  } result_t;

  function automatic logic [BYTE_W-1:0] slot_reset(input logic [SLOT_W-1:0] h);
    logic night;
    night = (h <= SLOT_W'(5)) || ((h >= SLOT_W'(17)) && (h <= SLOT_W'(22)));
    return night ? SLOT_ON : SLOT_OFF;
  endfunction

endpackage

[sv/tdrs_schedule.sv]
// hourly schedule store with day/night reset pattern
module tdrs_schedule
  import tdrs_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  sched_wr_t         wr_i,
  input  logic [SLOT_W-1:0] rd_slot_i,
  output logic [BYTE_W-1:0] rd_byte_o
);

  logic [BYTE_W-1:0] table_q [SLOTS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int h = 0; h < SLOTS; h++) begin
        table_q[h] <= slot_reset(SLOT_W'(h));
      end
    end else if (wr_i.en) begin
      table_q[wr_i.idx] <= wr_i.bits;
    end
  end

  assign rd_byte_o = table_q[rd_slot_i];

endmodule

[sv/tdrs_clock.sv]
// prescaler, time-of-day counters, event flags and relay latch
module tdrs_clock
  import tdrs_pkg::*;
#(
  parameter int unsigned TICKS_PER_SECOND = 10
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              fire_i,
  input  action_e           action_i,
  input  logic [HOUR_W-1:0] hour_value_i,
  input  logic [MIN_W-1:0]  minute_value_i,
  input  logic [SEC_W-1:0]  second_value_i,
  input  logic [SLOT_W-1:0] slot_index_i,
  input  logic [BYTE_W-1:0] slot_bits_i,
  input  logic [BYTE_W-1:0] sched_byte_i,
  output logic [SLOT_W-1:0] rd_slot_o,
  output sched_wr_t         wr_o,
  output result_t           res_o
);

  localparam int unsigned PW = $clog2(TICKS_PER_SECOND);
  localparam logic [PW-1:0] PRE_LAST = PW'(TICKS_PER_SECOND - 1);

  logic [PW-1:0]     pre_q, pre_d;
  logic [SEC_W-1:0]  sec_q, sec_d;
  logic [MIN_W-1:0]  min_q, min_d;
  logic [HOUR_W-1:0] hour_q, hour_d;
  logic              relay_q, relay_d;
  logic              boundary, sample, report;
  logic [2:0]        decade;

  always_comb begin
    pre_d    = pre_q;
    sec_d    = sec_q;
    min_d    = min_q;
    hour_d   = hour_q;
    boundary = 1'b0;
    wr_o     = '0;
    case (action_i)
      ACT_TICK: begin
        if (pre_q >= PRE_LAST) begin
          pre_d    = '0;
          boundary = 1'b1;
          if (sec_q >= SEC_MAX) begin
            sec_d = '0;
            if (min_q >= MIN_MAX) begin
              min_d  = '0;
              hour_d = (hour_q >= HOUR_MAX) ? '0 : hour_q + 1'b1;
            end else begin
              min_d = min_q + 1'b1;
            end
          end else begin
            sec_d = sec_q + 1'b1;
          end
        end else begin
          pre_d = pre_q + 1'b1;
        end
      end
      ACT_SET_TIME: begin
        hour_d = (hour_value_i > HOUR_MAX) ? HOUR_MAX : hour_value_i;
        min_d  = (minute_value_i > MIN_MAX) ? MIN_MAX : minute_value_i;
        sec_d  = (second_value_i > SEC_MAX) ? SEC_MAX : second_value_i;
      end
      ACT_WRITE_SLOT: begin
        wr_o.en   = fire_i && (slot_index_i < SLOT_W'(SLOTS));
        wr_o.idx  = slot_index_i;
        wr_o.bits = slot_bits_i;
      end
      default: begin
      end
    endcase
  end

  // minute / 10 for minutes 0..59
  always_comb begin
    if      (min_d >= MIN_W'(50)) decade = 3'd5;
    else if (min_d >= MIN_W'(40)) decade = 3'd4;
    else if (min_d >= MIN_W'(30)) decade = 3'd3;
    else if (min_d >= MIN_W'(20)) decade = 3'd2;
    else if (min_d >= MIN_W'(10)) decade = 3'd1;
    else                          decade = 3'd0;
  end

  assign rd_slot_o = hour_d;

  always_comb begin
    relay_d = boundary ? sched_byte_i[decade] : relay_q;
    sample  = boundary && ((sec_d == SEC_W'(1))  || (sec_d == SEC_W'(11)) ||
                           (sec_d == SEC_W'(21)) || (sec_d == SEC_W'(31)) ||
                           (sec_d == SEC_W'(41)) || (sec_d == SEC_W'(51)));
    report  = boundary && !sample &&
              ((sec_d == SEC_W'(6)) || (sec_d == SEC_W'(36)));
  end

  always_comb begin
    res_o.hour_now        = hour_d;
    res_o.minute_now      = min_d;
    res_o.second_now      = sec_d;
    res_o.second_boundary = boundary;
    res_o.sample_due      = sample;
    res_o.report_due      = report;
    res_o.relay_on        = relay_d;
    res_o.led_on          = sec_d[0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pre_q   <= '0;
      sec_q   <= '0;
      min_q   <= '0;
      hour_q  <= '0;
      relay_q <= 1'b0;
    end else if (fire_i) begin
      pre_q   <= pre_d;
      sec_q   <= sec_d;
      min_q   <= min_d;
      hour_q  <= hour_d;
      relay_q <= relay_d;
    end
  end

endmodule

[sv/time_of_day_relay_scheduler.sv]
// top level: input register, clock update, schedule store and result register
//
//   channel | direction | handshake                 | payload
//   in      | input     | in_valid_i / in_ready_o   | action, hour/minute/second value, slot
//   out     | output    | out_valid_o / out_ready_i | time now, event flags, relay, led
//
// one item per cycle sustained while the output is not stalled; a result beat is offered once
// its input beat has passed the input register and one update pass into the result register
// reset clears the counters and relay and loads the day/night schedule at once
// a stalled result holds in the output register while one more item waits in the
// input register; input ready drops only when both are full and the result is not taken
module time_of_day_relay_scheduler
  import tdrs_pkg::*;
#(
  parameter int unsigned TICKS_PER_SECOND = 10
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [1:0]        action_i,
  input  logic [HOUR_W-1:0] hour_value_i,
  input  logic [MIN_W-1:0]  minute_value_i,
  input  logic [SEC_W-1:0]  second_value_i,
  input  logic [SLOT_W-1:0] slot_index_i,
  input  logic [BYTE_W-1:0] slot_bits_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [HOUR_W-1:0] hour_now_o,
  output logic [MIN_W-1:0]  minute_now_o,
  output logic [SEC_W-1:0]  second_now_o,
  output logic              second_boundary_o,
  output logic              sample_due_o,
  output logic              report_due_o,
  output logic              relay_on_o,
  output logic              led_on_o
);

  logic              in_valid_q;
  action_e           action_q;
  logic [HOUR_W-1:0] hour_value_q;
  logic [MIN_W-1:0]  minute_value_q;
  logic [SEC_W-1:0]  second_value_q;
  logic [SLOT_W-1:0] slot_index_q;
  logic [BYTE_W-1:0] slot_bits_q;
  logic              out_valid_q;
  result_t           res_q, res_d;
  logic              advance, fire;
  logic [SLOT_W-1:0] rd_slot;
  logic [BYTE_W-1:0] sched_byte;
  sched_wr_t         sched_wr;

  assign advance    = !out_valid_q || out_ready_i;
  assign fire       = in_valid_q && advance;
  assign in_ready_o = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) in_valid_q <= in_valid_i;
      if (advance) out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      action_q       <= action_e'(action_i);
      hour_value_q   <= hour_value_i;
      minute_value_q <= minute_value_i;
      second_value_q <= second_value_i;
      slot_index_q   <= slot_index_i;
      slot_bits_q    <= slot_bits_i;
    end
    if (fire) res_q <= res_d;
  end

  tdrs_clock #(
    .TICKS_PER_SECOND(TICKS_PER_SECOND)
  ) u_clock (
    .clk_i,
    .rst_ni,
    .fire_i         (fire),
    .action_i       (action_q),
    .hour_value_i   (hour_value_q),
    .minute_value_i (minute_value_q),
    .second_value_i (second_value_q),
    .slot_index_i   (slot_index_q),
    .slot_bits_i    (slot_bits_q),
    .sched_byte_i   (sched_byte),
    .rd_slot_o      (rd_slot),
    .wr_o           (sched_wr),
    .res_o          (res_d)
  );

  tdrs_schedule u_schedule (
    .clk_i,
    .rst_ni,
    .wr_i      (sched_wr),
    .rd_slot_i (rd_slot),
    .rd_byte_o (sched_byte)
  );

  assign out_valid_o       = out_valid_q;
  assign hour_now_o        = res_q.hour_now;
  assign minute_now_o      = res_q.minute_now;
  assign second_now_o      = res_q.second_now;
  assign second_boundary_o = res_q.second_boundary;
  assign sample_due_o      = res_q.sample_due;
  assign report_due_o      = res_q.report_due;
  assign relay_on_o        = res_q.relay_on;
  assign led_on_o          = res_q.led_on;

endmodule

[sv/tdrs_checker.sv]
// port-level assertions for the time-of-day relay scheduler, with bind
module tdrs_checker
  import tdrs_pkg::*;
(
  input logic              clk_i,
  input logic              rst_ni,
  input logic              out_valid_o,
  input logic              out_ready_i,
  input logic [HOUR_W-1:0] hour_now_o,
  input logic [MIN_W-1:0]  minute_now_o,
  input logic [SEC_W-1:0]  second_now_o,
  input logic              second_boundary_o,
  input logic              sample_due_o,
  input logic              report_due_o,
  input logic              led_on_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result beat dropped while stalled");

  a_time_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (hour_now_o <= HOUR_MAX) && (minute_now_o <= MIN_MAX) &&
                    (second_now_o <= SEC_MAX))
    else $error("time of day out of range");

  a_events_on_boundary: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (sample_due_o || report_due_o) |-> second_boundary_o)
    else $error("event flag without second boundary");

  a_events_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(sample_due_o && report_due_o))
    else $error("sample and report both raised");

  a_led_odd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (led_on_o == second_now_o[0]))
    else $error("led does not follow odd second");

endmodule

bind time_of_day_relay_scheduler tdrs_checker u_tdrs_checker (
  .clk_i,
  .rst_ni,
  .out_valid_o,
  .out_ready_i,
  .hour_now_o,
  .minute_now_o,
  .second_now_o,
  .second_boundary_o,
  .sample_due_o,
  .report_due_o,
  .led_on_o
);
